/* hw/rtl/mlrp_pkg.sv */
// shared constants for the midi loop record/playback unit
// no dependencies
`default_nettype none
package mlrp_pkg;
	localparam int unsigned EventDepth = 64;
	localparam int unsigned MaxOut     = 64;
	localparam logic [31:0] LoopReset  = 32'd1920;

	localparam logic [1:0] REQ_BEGIN = 2'd0;
	localparam logic [1:0] REQ_MIDI  = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;
	localparam logic [1:0] REQ_ARM   = 2'd3;

	localparam logic [1:0] KIND_MIDI = 2'd0;
	localparam logic [1:0] KIND_NOTE = 2'd1;
	localparam logic [1:0] KIND_REC  = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_WAIT = 2'd1;
	localparam logic [1:0] MODE_REC  = 2'd2;
endpackage
`default_nettype wire

/* hw/rtl/midi_loop_record_playback_unit.sv */
// midi loop record/playback unit: event store memory, modulo unit, sequencer
// depends on mlrp_pkg
// timing: arm is registered; a midi item forwards its word first and the note word follows it;
// a tick begin runs two 40-step bit-serial modulo reductions before its state word (none
// when stopped); a tick end passes each event skipped in a seek through the read and check
// states, each played event also through the emit state, the played word held one step so the final one carries last
// one item at a time, input stalls until the last word has left the output register
// reset clears control state, the event store is not cleared
`default_nettype none
module midi_loop_record_playback_unit #(
	parameter int unsigned EVENT_DEPTH = mlrp_pkg::EventDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic        stopped,
	input  wire logic [39:0] start_ticks,
	input  wire logic [39:0] end_ticks,
	input  wire logic [7:0]  in_status,
	input  wire logic [7:0]  in_data1,
	input  wire logic [7:0]  in_data2,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_kind,
	output logic [31:0]      note_time,
	output logic [7:0]       out_status,
	output logic [7:0]       out_data1,
	output logic [7:0]       out_data2,
	output logic             was_recorded,
	output logic [1:0]       rec_state,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int CW = $clog2(EVENT_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(EVENT_DEPTH);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MODS  = 4'd1;
	localparam logic [3:0] ST_MODE  = 4'd2;
	localparam logic [3:0] ST_BEGIN = 4'd3;
	localparam logic [3:0] ST_MIDI  = 4'd4;
	localparam logic [3:0] ST_WIN   = 4'd5;
	localparam logic [3:0] ST_RD    = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]  st_q;
	logic [31:0] loop_len_q;
	logic [1:0]  mode_q;
	logic        arm_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pidx_q;
	logic [31:0] ppos_q;
	logic        pvalid_q;
	logic [31:0] cstart_q, cend_q;
	logic        cstop_q;

	// latched item
	logic        stop_q;
	logic [39:0] e_q;
	logic [23:0] midi_q;

	// bit-serial modulo
	logic [39:0] num_q;
	logic [31:0] rem_q;
	logic [5:0]  bit_q;
	logic [31:0] len_w;
	logic [32:0] rsh;
	logic [33:0] rdif;
	logic [31:0] rem_nx;

	// playback window
	logic [31:0] ws_q, we_q;
	logic        second_q;  // wrapped window pending second half
	logic        seek_q;
	logic [6:0]  nout_q;
	logic        any_q;
	logic        hold_q;
	logic [23:0] hold_midi_q;

	// memory: {time, status, data1, data2}
	logic [55:0] mem [EVENT_DEPTH];
	logic [55:0] rd_q;

	// output register
	logic        ovalid_q;
	logic [1:0]  okind_q;
	logic [31:0] otime_q;
	logic [23:0] omidi_q;
	logic        orec_q, olast_q;
	logic [1:0]  ostate_q;

	// pending notification after midi forward
	logic        note_pend_q;
	logic        note_rec_q;

	assign len_w  = (loop_len_q == 32'd0) ? 32'd1 : loop_len_q;
	assign rsh    = {rem_q, num_q[39]};
	assign rdif   = {1'b0, rsh} - {2'b00, len_w};
	assign rem_nx = rdif[33] ? rsh[31:0] : rdif[31:0];

	assign in_stall  = (st_q != ST_IDLE) || ovalid_q;
	assign cfg_ready = (st_q == ST_IDLE) && !ovalid_q;

	assign out_valid    = ovalid_q;
	assign out_kind     = okind_q;
	assign note_time    = otime_q;
	assign out_status   = omidi_q[23:16];
	assign out_data1    = omidi_q[15:8];
	assign out_data2    = omidi_q[7:0];
	assign was_recorded = orec_q;
	assign rec_state    = ostate_q;
	assign last         = olast_q;

	logic in_acc, out_free, out_load;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;

	// output register loads a new word this cycle
	assign out_load = out_free && (
		(st_q == ST_BEGIN && (any_q || (!stop_q && cstart_q == 32'd0 &&
			mode_q != mlrp_pkg::MODE_OFF))) ||
		(st_q == ST_MIDI) ||
		(st_q == ST_WIN && cend_q == cstart_q) ||
		(st_q == ST_EMIT && hold_q) ||
		(st_q == ST_DONE && !second_q && hold_q));

	logic [31:0] etime;
	assign etime = rd_q[55:24];

	// event store write and registered read
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	assign wr_en = (st_q == ST_MIDI) && !cstop_q && (mode_q == mlrp_pkg::MODE_REC) &&
		(count_q < DEPTH_C) && out_free && !note_pend_q;
	assign rd_addr = pidx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= {cstart_q, midi_q};
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			loop_len_q <= mlrp_pkg::LoopReset;
			mode_q <= mlrp_pkg::MODE_OFF;
			arm_q <= 1'b0;
			count_q <= '0;
			pidx_q <= '0;
			ppos_q <= '0;
			pvalid_q <= 1'b0;
			cstart_q <= '0;
			cend_q <= '0;
			cstop_q <= 1'b1;
			ovalid_q <= 1'b0;
			note_pend_q <= 1'b0;
			note_rec_q <= 1'b0;
			stop_q <= 1'b0;
			e_q <= '0;
			midi_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			ws_q <= '0;
			we_q <= '0;
			second_q <= 1'b0;
			seek_q <= 1'b0;
			nout_q <= '0;
			any_q <= 1'b0;
			hold_q <= 1'b0;
			hold_midi_q <= '0;
			okind_q <= '0;
			otime_q <= '0;
			omidi_q <= '0;
			orec_q <= 1'b0;
			olast_q <= 1'b0;
			ostate_q <= '0;
		end else begin
			if (ovalid_q && !out_stall && !out_load) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				loop_len_q <= cfg_data;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						stop_q <= stopped;
						e_q <= end_ticks;
						midi_q <= {in_status, in_data1, in_data2};
						unique case (req_type)
							mlrp_pkg::REQ_ARM: arm_q <= 1'b1;
							mlrp_pkg::REQ_BEGIN: begin
								// apply pending arm first
								if (arm_q) begin
									arm_q <= 1'b0;
									mode_q <= mlrp_pkg::MODE_WAIT;
									any_q <= 1'b1;
								end else begin
									any_q <= 1'b0;
								end
								cstop_q <= stopped;
								if (stopped) begin
									st_q <= ST_BEGIN;
								end else begin
									num_q <= start_ticks;
									rem_q <= '0;
									bit_q <= '0;
									st_q <= ST_MODS;
								end
							end
							mlrp_pkg::REQ_MIDI: begin
								note_pend_q <= 1'b0;
								st_q <= ST_MIDI;
							end
							mlrp_pkg::REQ_END: begin
								nout_q <= '0;
								if (!cstop_q && mode_q == mlrp_pkg::MODE_OFF &&
									count_q != '0) begin
									st_q <= ST_WIN;
								end
							end
						endcase
					end
				end
				ST_MODS, ST_MODE: begin
					// restoring division step, one bit per cycle
					if (bit_q == 6'd39) begin
						if (st_q == ST_MODS) begin
							cstart_q <= rem_nx;
							num_q <= e_q;
							rem_q <= '0;
							bit_q <= '0;
							st_q <= ST_MODE;
						end else begin
							cend_q <= (rem_nx == 32'd0) ? len_w : rem_nx;
							st_q <= ST_BEGIN;
						end
					end else begin
						num_q <= {num_q[38:0], 1'b0};
						rem_q <= rem_nx;
						bit_q <= bit_q + 6'd1;
					end
				end
				ST_BEGIN: begin
					// report arm, then origin transition
					if (out_free) begin
						if (any_q) begin
							any_q <= 1'b0;
							ovalid_q <= 1'b1;
							okind_q <= mlrp_pkg::KIND_REC;
							otime_q <= '0;
							omidi_q <= '0;
							orec_q <= 1'b0;
							ostate_q <= mode_q;
							olast_q <= stop_q || cstart_q != 32'd0 ||
								mode_q == mlrp_pkg::MODE_OFF;
							if (stop_q || cstart_q != 32'd0 ||
								mode_q == mlrp_pkg::MODE_OFF) begin
								st_q <= ST_IDLE;
							end
						end else begin
							st_q <= ST_IDLE;
							if (!stop_q && cstart_q == 32'd0 &&
								mode_q != mlrp_pkg::MODE_OFF) begin
								ovalid_q <= 1'b1;
								okind_q <= mlrp_pkg::KIND_REC;
								otime_q <= '0;
								omidi_q <= '0;
								orec_q <= 1'b0;
								olast_q <= 1'b1;
								if (mode_q == mlrp_pkg::MODE_WAIT) begin
									mode_q <= mlrp_pkg::MODE_REC;
									count_q <= '0;
									ostate_q <= mlrp_pkg::MODE_REC;
								end else begin
									mode_q <= mlrp_pkg::MODE_OFF;
									pvalid_q <= 1'b0;
									ppos_q <= '0;
									pidx_q <= '0;
									ostate_q <= mlrp_pkg::MODE_OFF;
								end
							end
						end
					end
				end
				ST_MIDI: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						omidi_q <= midi_q;
						ostate_q <= mode_q;
						if (cstop_q) begin
							okind_q <= mlrp_pkg::KIND_NOTE;
							otime_q <= '0;
							orec_q <= 1'b0;
							olast_q <= 1'b1;
							st_q <= ST_IDLE;
						end else if (note_pend_q) begin
							okind_q <= mlrp_pkg::KIND_NOTE;
							otime_q <= cstart_q;
							orec_q <= note_rec_q;
							olast_q <= 1'b1;
							st_q <= ST_IDLE;
						end else begin
							note_rec_q <= wr_en;
							if (wr_en) begin
								count_q <= count_q + CW'(1);
							end
							orec_q <= 1'b0;
							if (mode_q != mlrp_pkg::MODE_OFF) begin
								okind_q <= mlrp_pkg::KIND_MIDI;
								otime_q <= '0;
								olast_q <= 1'b0;
								note_pend_q <= 1'b1;
							end else begin
								okind_q <= mlrp_pkg::KIND_NOTE;
								otime_q <= cstart_q;
								olast_q <= 1'b1;
								st_q <= ST_IDLE;
							end
						end
					end
				end
				ST_WIN: begin
					// set up the first window
					hold_q <= 1'b0;
					if (cend_q > cstart_q) begin
						ws_q <= cstart_q;
						we_q <= cend_q;
						second_q <= 1'b0;
						seek_q <= !pvalid_q || ppos_q != cstart_q;
						if (!pvalid_q || ppos_q != cstart_q) pidx_q <= '0;
						st_q <= ST_RD;
					end else if (cend_q < cstart_q) begin
						ws_q <= cstart_q;
						we_q <= len_w;
						second_q <= 1'b1;
						seek_q <= !pvalid_q || ppos_q != cstart_q;
						if (!pvalid_q || ppos_q != cstart_q) pidx_q <= '0;
						st_q <= ST_RD;
					end else if (out_free) begin
						second_q <= 1'b0;
						ovalid_q <= 1'b1;
						okind_q <= mlrp_pkg::KIND_ERR;
						otime_q <= '0;
						omidi_q <= '0;
						orec_q <= 1'b0;
						ostate_q <= mode_q;
						olast_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					// address presented, read data next cycle
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					if (pidx_q >= count_q) begin
						st_q <= ST_DONE;
					end else if (seek_q) begin
						if (etime < ws_q) begin
							pidx_q <= pidx_q + CW'(1);
							st_q <= ST_RD;
						end else begin
							seek_q <= 1'b0;
						end
					end else if (nout_q == 7'(mlrp_pkg::MaxOut) || etime < ws_q ||
						etime >= we_q) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold back one word so the final one can carry last
					if (!hold_q || out_free) begin
						if (hold_q) begin
							ovalid_q <= 1'b1;
							okind_q <= mlrp_pkg::KIND_MIDI;
							otime_q <= '0;
							omidi_q <= hold_midi_q;
							orec_q <= 1'b0;
							ostate_q <= mode_q;
							olast_q <= 1'b0;
						end
						hold_q <= 1'b1;
						hold_midi_q <= rd_q[23:0];
						nout_q <= nout_q + 7'd1;
						pidx_q <= pidx_q + CW'(1);
						st_q <= ST_RD;
					end
				end
				ST_DONE: begin
					ppos_q <= we_q;
					pvalid_q <= 1'b1;
					if (second_q) begin
						second_q <= 1'b0;
						ws_q <= '0;
						we_q <= cend_q;
						seek_q <= we_q != 32'd0;
						if (we_q != 32'd0) pidx_q <= '0;
						st_q <= ST_RD;
					end else if (!hold_q) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						// release the held final word with last
						ovalid_q <= 1'b1;
						okind_q <= mlrp_pkg::KIND_MIDI;
						otime_q <= '0;
						omidi_q <= hold_midi_q;
						orec_q <= 1'b0;
						ostate_q <= mode_q;
						olast_q <= 1'b1;
						hold_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sim/tb_midi_loop_record_playback_unit.sv */
// testbench for the midi loop record/playback unit: directed table, then random
// loop takes checked against a behavioral predictor; depends on mlrp_pkg and the rtl
`timescale 1ns / 1ps
module tb_midi_loop_record_playback_unit;
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] ntime;
		logic [7:0]  st;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic        rec;
		logic [1:0]  mode;
		logic        fin;
	} result_t;

	typedef struct {
		logic [1:0]  req;
		logic        stp;
		logic [39:0] s;
		logic [39:0] e;
		logic [7:0]  st;
		logic [7:0]  d1;
		logic [7:0]  d2;
	} item_t;

	typedef struct {
		item_t   it;
		bit      chk;
		result_t res;
	} row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = mlrp_pkg::REQ_BEGIN;
	logic        stopped = 1'b0;
	logic [39:0] start_ticks = '0;
	logic [39:0] end_ticks = '0;
	logic [7:0]  in_status = '0;
	logic [7:0]  in_data1 = '0;
	logic [7:0]  in_data2 = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  out_kind;
	logic [31:0] note_time;
	logic [7:0]  out_status;
	logic [7:0]  out_data1;
	logic [7:0]  out_data2;
	logic        was_recorded;
	logic [1:0]  rec_state;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	midi_loop_record_playback_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .stopped(stopped),
		.start_ticks(start_ticks), .end_ticks(end_ticks),
		.in_status(in_status), .in_data1(in_data1), .in_data2(in_data2),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_kind(out_kind), .note_time(note_time),
		.out_status(out_status), .out_data1(out_data1), .out_data2(out_data2),
		.was_recorded(was_recorded), .rec_state(rec_state), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// loop state mirror
	logic [31:0] p_len = mlrp_pkg::LoopReset;
	logic [1:0]  p_mode = mlrp_pkg::MODE_OFF;
	bit          p_arm = 0;
	int          p_count = 0;
	logic [31:0] ev_time [mlrp_pkg::EventDepth];
	logic [23:0] ev_bytes [mlrp_pkg::EventDepth];
	int          p_pidx = 0;
	logic [31:0] p_ppos = '0;
	bit          p_pvalid = 0;
	logic [31:0] p_start = '0;
	logic [31:0] p_end = '0;
	bit          p_stopped = 1;

	result_t pending_words [$];
	result_t batch [$];
	int      mismatches = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      items_sent = 0;

	function automatic void flag(string what, result_t e, result_t g);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s): exp kind=%0d time=%0d bytes=%h %h %h rec=%0d mode=%0d last=%0d",
				what, e.kind, e.ntime, e.st, e.d1, e.d2, e.rec, e.mode, e.fin);
			$display("  got kind=%0d time=%0d bytes=%h %h %h rec=%0d mode=%0d last=%0d",
				g.kind, g.ntime, g.st, g.d1, g.d2, g.rec, g.mode, g.fin);
		end
	endfunction

	function automatic void emit_word(logic [1:0] kind, logic [31:0] t, logic [23:0] b,
			logic rec);
		if (batch.size() < mlrp_pkg::MaxOut)
			batch.push_back('{kind, t, b[23:16], b[15:8], b[7:0], rec, p_mode, 1'b0});
	endfunction

	// play stored events in [ws, we), seeking again after a jump
	function automatic void play_window(logic [31:0] ws, logic [31:0] we);
		if (!p_pvalid || p_ppos != ws) begin
			p_pidx = 0;
			while (p_pidx < p_count && ev_time[p_pidx] < ws)
				p_pidx++;
		end
		while (p_pidx < p_count && batch.size() < mlrp_pkg::MaxOut) begin
			if (ev_time[p_pidx] < ws || ev_time[p_pidx] >= we)
				break;
			emit_word(mlrp_pkg::KIND_MIDI, '0, ev_bytes[p_pidx], 1'b0);
			p_pidx++;
		end
		p_ppos = we;
		p_pvalid = 1;
	endfunction

	// expected words for one accepted item
	function automatic void predict_words(item_t it);
		logic [63:0] len;
		logic [23:0] b;
		logic rec;
		len = (p_len == 0) ? 64'd1 : {32'd0, p_len};
		b = {it.st, it.d1, it.d2};
		batch.delete();
		case (it.req)
			mlrp_pkg::REQ_ARM: p_arm = 1;
			mlrp_pkg::REQ_BEGIN: begin
				if (p_arm) begin
					p_arm = 0;
					p_mode = mlrp_pkg::MODE_WAIT;
					emit_word(mlrp_pkg::KIND_REC, '0, '0, 1'b0);
				end
				p_stopped = it.stp;
				if (!p_stopped) begin
					p_start = 32'({24'd0, it.s} % len);
					p_end = 32'({24'd0, it.e} % len);
					if (p_end == 0)
						p_end = len[31:0];
					if (p_start == 0) begin
						if (p_mode == mlrp_pkg::MODE_WAIT) begin
							p_mode = mlrp_pkg::MODE_REC;
							p_count = 0;
							emit_word(mlrp_pkg::KIND_REC, '0, '0, 1'b0);
						end else if (p_mode == mlrp_pkg::MODE_REC) begin
							p_mode = mlrp_pkg::MODE_OFF;
							p_pvalid = 0;
							p_ppos = '0;
							p_pidx = 0;
							emit_word(mlrp_pkg::KIND_REC, '0, '0, 1'b0);
						end
					end
				end
			end
			mlrp_pkg::REQ_MIDI: begin
				if (p_stopped) begin
					emit_word(mlrp_pkg::KIND_NOTE, '0, b, 1'b0);
				end else begin
					rec = 1'b0;
					if (p_mode == mlrp_pkg::MODE_REC && p_count < mlrp_pkg::EventDepth) begin
						ev_time[p_count] = p_start;
						ev_bytes[p_count] = b;
						p_count++;
						rec = 1'b1;
					end
					if (p_mode != mlrp_pkg::MODE_OFF)
						emit_word(mlrp_pkg::KIND_MIDI, '0, b, 1'b0);
					emit_word(mlrp_pkg::KIND_NOTE, p_start, b, rec);
				end
			end
			default: begin
				if (!p_stopped && p_mode == mlrp_pkg::MODE_OFF && p_count > 0) begin
					if (p_end > p_start) begin
						play_window(p_start, p_end);
					end else if (p_end < p_start) begin
						play_window(p_start, len[31:0]);
						play_window('0, p_end);
					end else begin
						emit_word(mlrp_pkg::KIND_ERR, '0, '0, 1'b0);
					end
				end
			end
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].fin = 1'b1;
		foreach (batch[i])
			pending_words.push_back(batch[i]);
	endfunction

	// receiver stall
	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	// result checker
	result_t got_word;
	result_t want_word;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_word = '{out_kind, note_time, out_status, out_data1, out_data2,
				was_recorded, rec_state, last};
			if (pending_words.size() == 0) begin
				flag("unexpected word", '0, got_word);
			end else begin
				want_word = pending_words.pop_front();
				if (got_word !== want_word)
					flag("result", want_word, got_word);
			end
		end
	end

	task automatic send(item_t it);
		req_type <= it.req;
		stopped <= it.stp;
		start_ticks <= it.s;
		end_ticks <= it.e;
		in_status <= it.st;
		in_data1 <= it.d1;
		in_data2 <= it.d2;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_words(it);
		items_sent++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// wait until every expected word is in, then let a trailing scan finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic write_loop_length(logic [31:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		p_len = v;
		@(posedge clk);
	endtask

	function automatic item_t mk(logic [1:0] req, logic stp, logic [39:0] s, logic [39:0] e,
			logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
		item_t it;
		it = '{req, stp, s, e, st, d1, d2};
		return it;
	endfunction

	// absolute tick value that lands on loop position pos
	function automatic logic [39:0] abs_at(logic [63:0] pos);
		logic [63:0] len;
		logic [63:0] kmax;
		len = (p_len == 0) ? 64'd1 : {32'd0, p_len};
		kmax = (64'hFF_FFFF_FFFF - pos) / len;
		return 40'(({$urandom, $urandom} % (kmax + 1)) * len + pos);
	endfunction

	function automatic logic [63:0] rand_pos(bit nonzero);
		logic [63:0] len;
		len = (p_len == 0) ? 64'd1 : {32'd0, p_len};
		if (nonzero && len > 1)
			return 64'd1 + ({$urandom, $urandom} % (len - 1));
		return {$urandom, $urandom} % len;
	endfunction

	task automatic send_begin(logic [63:0] pos, logic [63:0] span);
		logic [39:0] s;
		s = abs_at(pos);
		send(mk(mlrp_pkg::REQ_BEGIN, 1'b0, s, s + 40'(span), '0, '0, '0));
	endtask

	task automatic send_midi();
		send(mk(mlrp_pkg::REQ_MIDI, 1'b0, '0, '0, 8'($urandom), 8'($urandom),
			8'($urandom)));
	endtask

	task automatic send_noise();
		send(mk(2'($urandom), 1'($urandom), {8'($urandom), 32'($urandom)},
			{8'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom), 8'($urandom)));
	endtask

	function automatic logic [63:0] rand_span();
		logic [63:0] len;
		len = (p_len == 0) ? 64'd1 : {32'd0, p_len};
		case ($urandom_range(5))
			0: return 64'd0;
			1: return len;
			2: return {$urandom, $urandom} % (2 * len);
			default: return {$urandom, $urandom} % (len / 2 + 1);
		endcase
	endfunction

	// one take: arm, wait for origin, record a few segments, then play back
	task automatic loop_take(bit burst);
		int n;
		logic [63:0] pos;
		logic [63:0] span;
		send(mk(mlrp_pkg::REQ_ARM, 1'($urandom), '0, '0, '0, '0, '0));
		if ($urandom_range(3) == 0)
			send_noise();
		send_begin(rand_pos(1), rand_span());
		send_begin(64'd0, rand_span());
		repeat ($urandom_range(1, 2)) begin
			n = burst ? 66 : $urandom_range(1, 4);
			burst = 0;
			repeat (n) send_midi();
			if ($urandom_range(4) == 0) begin
				send(mk(mlrp_pkg::REQ_BEGIN, 1'b1, '0, '0, '0, '0, '0));
				send_midi();
			end
			send_begin(rand_pos(1), rand_span());
		end
		send_begin(64'd0, rand_span());
		pos = rand_pos(0);
		repeat ($urandom_range(1, 4)) begin
			span = rand_span();
			send_begin(pos, span);
			send(mk(mlrp_pkg::REQ_END, 1'($urandom), '0, '0, '0, '0, '0));
			if ($urandom_range(3) == 0)
				pos = rand_pos(0);
			else
				pos = (pos + span) % ((p_len == 0) ? 64'd1 : {32'd0, p_len});
		end
		if ($urandom_range(2) == 0)
			send_noise();
	endtask

	// directed table
	row_t rows [$];
	task automatic add_row(item_t it, bit chk, result_t res);
		rows.push_back('{it, chk, res});
	endtask

	logic [31:0] lengths [6] = '{32'd16, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7,
		mlrp_pkg::LoopReset};
	int idle_set [4] = '{0, 53, 0, 17};
	int stall_set [4] = '{0, 0, 53, 17};

	initial begin
		add_row(mk(mlrp_pkg::REQ_MIDI, 0, '0, '0, 8'h90, 8'h3c, 8'h64), 1,
			'{mlrp_pkg::KIND_NOTE, 32'd0, 8'h90, 8'h3c, 8'h64, 1'b0,
			mlrp_pkg::MODE_OFF, 1'b1});
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_ARM, 0, '1, '1, '1, '1, '1), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 1, '0, '0, '0, '0, '0), 1,
			'{mlrp_pkg::KIND_REC, 32'd0, 8'h00, 8'h00, 8'h00, 1'b0,
			mlrp_pkg::MODE_WAIT, 1'b1});
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd100, 40'd200, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_MIDI, 0, '0, '0, 8'hff, 8'hff, 8'hff), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd5760, 40'd5810, '0, '0, '0), 1,
			'{mlrp_pkg::KIND_REC, 32'd0, 8'h00, 8'h00, 8'h00, 1'b0,
			mlrp_pkg::MODE_REC, 1'b1});
		add_row(mk(mlrp_pkg::REQ_MIDI, 0, '0, '0, 8'h90, 8'h3c, 8'h7f), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, '1, '1, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_MIDI, 0, '0, '0, 8'h00, 8'h00, 8'h00), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd700, 40'd900, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_MIDI, 0, '0, '0, 8'h80, 8'h3c, 8'h00), 0, '0);
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd1920, 40'd2020, '0, '0, '0), 1,
			'{mlrp_pkg::KIND_REC, 32'd0, 8'h00, 8'h00, 8'h00, 1'b0,
			mlrp_pkg::MODE_OFF, 1'b1});
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd0, 40'd1920, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd1900, 40'd1950, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd500, 40'd500, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 1,
			'{mlrp_pkg::KIND_ERR, 32'd0, 8'h00, 8'h00, 8'h00, 1'b0,
			mlrp_pkg::MODE_OFF, 1'b1});
		add_row(mk(mlrp_pkg::REQ_BEGIN, 0, 40'd800, 40'd10, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_BEGIN, 1, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(mlrp_pkg::REQ_END, 0, '0, '0, '0, '0, '0), 0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows, typed results cross-checked with the mirror
		foreach (rows[i]) begin
			send(rows[i].it);
			if (rows[i].chk && (batch.size() != 1 || batch[0] !== rows[i].res))
				flag("directed row", rows[i].res, (batch.size() > 0) ? batch[0] : '0);
		end
		drain();

		// random takes over several loop lengths and idle patterns
		foreach (lengths[ph]) begin
			write_loop_length(lengths[ph]);
			idle_pct = idle_set[ph % 4];
			stall_pct = stall_set[ph % 4];
			items_sent = 0;
			loop_take(ph == 0);
			if (ph == 1)
				drain();
			while (items_sent < 8) begin
				if ($urandom_range(4) == 0)
					send_noise();
				else
					loop_take(0);
			end
			drain();
			stall_pct = 0;
		end

		if (mismatches == 0 && pending_words.size() == 0)
			$display("** midi_loop_record_playback_unit: PASSED **");
		else
			$display("** midi_loop_record_playback_unit: FAILED **");
		$finish;
	end

	// run time limit
	initial begin
		#20000000;
		$display("** midi_loop_record_playback_unit: FAILED **");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/mlrp_pkg.sv
hw/rtl/midi_loop_record_playback_unit.sv
sim/tb_midi_loop_record_playback_unit.sv
